FILE: sv/transpose_list_lookup_unit_macros.svh
// Assertion helpers shared by the list lookup RTL.
`ifndef TRANSPOSE_LIST_LOOKUP_UNIT_MACROS_SVH
`define TRANSPOSE_LIST_LOOKUP_UNIT_MACROS_SVH

// Checked on every rising edge outside of reset.
`define TLL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define TLL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: sv/tll_pkg.sv
`default_nettype none

package tll_pkg;

  localparam int KEY_W     = 32;
  localparam int POS_W     = 5;
  localparam int CAP_W     = 5;
  localparam int OCC_W     = 5;
  localparam int CAP_RESET = 16;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SEARCH = 4'b0010,
    ST_SWAP   = 4'b0100,
    ST_RESULT = 4'b1000
  } state_t;

endpackage

`default_nettype wire

FILE: sv/tll_lookup_if.sv
`default_nettype none

interface tll_lookup_if import tll_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [KEY_W-1:0] lookup_key;

  modport source (output valid, output lookup_key, input ready);
  modport sink   (input valid, input lookup_key, output ready);
endinterface

`default_nettype wire

FILE: sv/tll_result_if.sv
`default_nettype none

interface tll_result_if import tll_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             hit;
  logic [POS_W-1:0] found_position;
  logic             evicted;
  logic [KEY_W-1:0] evicted_key;
  logic [OCC_W-1:0] occupancy;

  modport source (output valid, output hit, output found_position, output evicted,
                  output evicted_key, output occupancy, input ready);
  modport sink   (input valid, input hit, input found_position, input evicted,
                  input evicted_key, input occupancy, output ready);
endinterface

`default_nettype wire

FILE: sv/transpose_list_lookup_unit.sv
// Channel   Direction  Payload
// lookup    in         lookup_key
// result    out        hit, found_position, evicted, evicted_key, occupancy
// cfg       in         cfg_wr_data (capacity), written when cfg_wr_en is high
//
// An item's lookup is taken only in idle; the next one waits until its result has gone
// into the output register, and a hit behind the head adds a swap step first.
// The search walks the key RAM through its single read port, one entry per cycle.
// With an empty list the key is appended at the head without a search.
// Reset (rst, synchronous) empties the list and sets capacity to 16; the RAM keeps
// its contents, since only entries below the occupancy are ever compared.
// A stalled result sits in the output register while the next lookup is taken.
`default_nettype none
`include "transpose_list_lookup_unit_macros.svh"

module transpose_list_lookup_unit import tll_pkg::*; #(
  parameter int DEPTH    = 16,
  parameter int KEY_BITS = 32
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_wr_en,
  input  wire logic [CAP_W-1:0] cfg_wr_data,
  tll_lookup_if.sink            lookup,
  tll_result_if.source          result
);

  // Stored key width: key bits above KEY_BITS are ignored, and the port holds 32.
  localparam int KW = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  // Width for position and capacity arithmetic, wide enough for DEPTH + 1.
  localparam int PW = (CW + 1 > CAP_W) ? CW + 1 : CAP_W;

  state_t           state, state_next;
  logic [KW-1:0]    key_r, key_r_next;
  logic [CW-1:0]    iss, iss_next;
  logic [CW-1:0]    cmp, cmp_next;
  logic             rvalid, rvalid_next;
  logic [KW-1:0]    prev_key, prev_key_next;
  logic [CW-1:0]    count, count_next;
  logic [CAP_W-1:0] capacity;
  logic [AW-1:0]    swap_addr, swap_addr_next;

  logic             res_hit, res_hit_next;
  logic [POS_W-1:0] res_pos, res_pos_next;
  logic             res_ev, res_ev_next;
  logic [KW-1:0]    res_evkey, res_evkey_next;

  logic             ram_wr_en;
  logic [AW-1:0]    ram_wr_addr;
  logic [KW-1:0]    ram_wr_data;
  logic [KW-1:0]    ram_rd_data;

  logic [PW-1:0]    eff_cap;
  logic             key_match;
  logic             last_entry;
  logic             do_evict;
  logic             load_out;

  // The read port follows the issue counter; data for entry cmp arrives registered, in the cycle after its address.
  tll_ram #(
    .WIDTH (KW),
    .DEPTH (DEPTH)
  ) u_key_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_addr (iss[AW-1:0]),
    .rd_data (ram_rd_data)
  );

  // A capacity of zero behaves as one; anything above DEPTH behaves as DEPTH.
  always_comb begin
    eff_cap = (capacity == '0) ? PW'(1) : PW'(capacity);
    if (eff_cap > PW'(DEPTH)) begin
      eff_cap = PW'(DEPTH);
    end
  end

  // The one shared comparator of the search.
  assign key_match  = (ram_rd_data == key_r);
  assign last_entry = ((cmp + CW'(1)) == count);
  assign do_evict   = (PW'(count) >= eff_cap);

  assign lookup.ready = (state == ST_IDLE);
  assign load_out     = (state == ST_RESULT) && (!result.valid || result.ready);

  always_comb begin
    state_next     = state;
    key_r_next     = key_r;
    iss_next       = iss;
    cmp_next       = cmp;
    rvalid_next    = 1'b0;
    prev_key_next  = prev_key;
    count_next     = count;
    swap_addr_next = swap_addr;
    res_hit_next   = res_hit;
    res_pos_next   = res_pos;
    res_ev_next    = res_ev;
    res_evkey_next = res_evkey;
    ram_wr_en      = 1'b0;
    ram_wr_addr    = count[AW-1:0];
    ram_wr_data    = key_r;

    case (state)
      ST_IDLE: begin
        if (lookup.valid) begin
          key_r_next = lookup.lookup_key[KW-1:0];
          iss_next   = '0;
          cmp_next   = '0;
          if (count == '0) begin
            // Empty list: a plain append at the head.
            ram_wr_en      = 1'b1;
            ram_wr_addr    = '0;
            ram_wr_data    = lookup.lookup_key[KW-1:0];
            count_next     = CW'(1);
            res_hit_next   = 1'b0;
            res_pos_next   = POS_W'(1);
            res_ev_next    = 1'b0;
            res_evkey_next = '0;
            state_next     = ST_RESULT;
          end else begin
            state_next = ST_SEARCH;
          end
        end
      end

      ST_SEARCH: begin
        if (iss < count) begin
          iss_next    = iss + CW'(1);
          rvalid_next = 1'b1;
        end
        if (rvalid) begin
          if (key_match) begin
            res_hit_next   = 1'b1;
            res_pos_next   = POS_W'(PW'(cmp) + PW'(1));
            res_ev_next    = 1'b0;
            res_evkey_next = '0;
            rvalid_next    = 1'b0;
            if (cmp != '0) begin
              // Move the key forward now; the displaced entry follows next cycle.
              ram_wr_en      = 1'b1;
              ram_wr_addr    = AW'(cmp - CW'(1));
              ram_wr_data    = key_r;
              swap_addr_next = cmp[AW-1:0];
              state_next     = ST_SWAP;
            end else begin
              state_next = ST_RESULT;
            end
          end else if (last_entry) begin
            // Miss: the entry just read is the tail, evicted if the list is full.
            res_hit_next   = 1'b0;
            res_pos_next   = POS_W'(PW'(count) + PW'(1));
            res_ev_next    = do_evict;
            res_evkey_next = do_evict ? ram_rd_data : '0;
            ram_wr_en      = 1'b1;
            ram_wr_addr    = do_evict ? AW'(count - CW'(1)) : count[AW-1:0];
            ram_wr_data    = key_r;
            count_next     = do_evict ? count : count + CW'(1);
            rvalid_next    = 1'b0;
            state_next     = ST_RESULT;
          end else begin
            prev_key_next = ram_rd_data;
            cmp_next      = cmp + CW'(1);
          end
        end
      end

      ST_SWAP: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = swap_addr;
        ram_wr_data = prev_key;
        state_next  = ST_RESULT;
      end

      ST_RESULT: begin
        if (load_out) begin
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      count        <= '0;
      capacity     <= CAP_W'(CAP_RESET);
      rvalid       <= 1'b0;
      result.valid <= 1'b0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      rvalid <= rvalid_next;
      if (cfg_wr_en) begin
        capacity <= cfg_wr_data;
      end
      if (load_out) begin
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    key_r     <= key_r_next;
    iss       <= iss_next;
    cmp       <= cmp_next;
    prev_key  <= prev_key_next;
    swap_addr <= swap_addr_next;
    res_hit   <= res_hit_next;
    res_pos   <= res_pos_next;
    res_ev    <= res_ev_next;
    res_evkey <= res_evkey_next;
    if (load_out) begin
      result.hit            <= res_hit;
      result.found_position <= res_pos;
      result.evicted        <= res_ev;
      result.evicted_key    <= KEY_W'(res_evkey);
      result.occupancy      <= OCC_W'(PW'(count));
    end
  end

  `TLL_ASSERT(a_count_bound, count <= CW'(DEPTH), "occupancy exceeds DEPTH")
  `TLL_ASSERT(a_write_in_list, ram_wr_en |-> (CW'(ram_wr_addr) <= count), "write past the tail")
  `TLL_ASSERT(a_read_ahead, (state == ST_SEARCH && rvalid) |-> (cmp < iss), "compare without read")
  `TLL_ASSERT(a_evict_on_miss, (result.valid && result.evicted) |-> !result.hit, "evict on a hit")

endmodule

`default_nettype wire

FILE: sv/tll_ram.sv
`default_nettype none

// Simple dual-port RAM: one write port, one read port with registered data.
module tll_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire
